/* design/assert_macros.svh */
// Assertion macros for the checked RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted
`define RLPSD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define RLPSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/rlpsd_pkg.sv */
// Shared types and constants of the LED panel scan driver
`default_nettype none

package rlpsd_pkg;

    localparam int DEF_PANEL_COLUMNS = 64;
    localparam int DEF_SCAN_LINES    = 16;

    localparam int OP_W      = 2;
    localparam int COLOR_W   = 3;
    localparam int ROW_IN_W  = 5;
    localparam int COL_IN_W  = 6;
    localparam int COL_OUT_W = 6;
    localparam int LINE_OUT_W = 4;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
    localparam logic [OP_W-1:0] OP_REFRESH = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic pix_write;
        logic clr_step;
        logic scan_step;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sweep_last;
        logic col_last;
        logic rd_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* design/rlpsd_ram.sv */
// Generic simple dual-port RAM with registered read
`default_nettype none

module rlpsd_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/rlpsd_ctrl.sv */
// Controller state machine: clearing sweep, idle and line scan
`default_nettype none

module rlpsd_ctrl
    import rlpsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [OP_W-1:0]  operation,
    output logic                  in_ready,
    input  wire dp_status_t       status,
    output ctrl_cmd_t             cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (operation)
                        OP_WRITE:   cmd.pix_write = 1'b1;
                        OP_CLEAR:   state_next = ST_CLEAR;
                        OP_REFRESH: state_next = ST_SCAN;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // advance only when the read data register is free to take a column
                if (status.rd_free)
                begin
                    cmd.scan_step = 1'b1;
                    if (status.col_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/rlpsd_datapath.sv */
// Datapath: frame store halves, sweep, column and line counters, result registers
`default_nettype none

module rlpsd_datapath
    import rlpsd_pkg::*;
#(
    parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
    parameter int SCAN_LINES    = DEF_SCAN_LINES
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    input  wire logic [ROW_IN_W-1:0]   pixel_row,
    input  wire logic [COL_IN_W-1:0]   pixel_column,
    input  wire logic [COLOR_W-1:0]    pixel_color,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COLOR_W-1:0]         upper_rgb,
    output logic [COLOR_W-1:0]         lower_rgb,
    output logic [COL_OUT_W-1:0]       shift_column,
    output logic [LINE_OUT_W-1:0]      line_address,
    output logic                       last_of_line
);

    localparam int COL_W  = $clog2(PANEL_COLUMNS);
    localparam int LINE_W = $clog2(SCAN_LINES);
    localparam int ADDR_W = COL_W + LINE_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    logic [ADDR_W-1:0]     sweep_reg;
    logic [COL_W-1:0]      col_reg;
    logic [LINE_W-1:0]     line_reg;
    logic                  out_valid_reg;
    logic [COL_OUT_W-1:0]  out_col_reg;
    logic [LINE_OUT_W-1:0] out_line_reg;
    logic                  out_last_reg;

    logic                  rd_free;
    logic                  col_last;
    logic [COL_W+COL_OUT_W-1:0]   col_ext;
    logic [LINE_W+LINE_OUT_W-1:0] line_ext;

    logic [6:0]            row_ext;
    logic [6:0]            row_in_half;
    logic                  row_upper;
    logic                  row_ok;
    logic [8:0]            pcol_ext;
    logic                  pcol_ok;
    logic [LINE_W-1:0]     row_line;
    logic [COL_W-1:0]      pcol_idx;

    logic                  we_upper;
    logic                  we_lower;
    logic [ADDR_W-1:0]     waddr;
    logic [COLOR_W-1:0]    wdata;
    logic [ADDR_W-1:0]     raddr;

    assign rd_free  = !out_valid_reg || out_ready;
    assign col_last = (col_reg == COL_W'(PANEL_COLUMNS - 1));
    assign col_ext  = {{COL_OUT_W{1'b0}}, col_reg};
    assign line_ext = {{LINE_OUT_W{1'b0}}, line_reg};

    // Map a frame row onto a half and a line within that half
    assign row_ext     = {2'b00, pixel_row};
    assign row_upper   = (row_ext < 7'(SCAN_LINES));
    assign row_ok      = (row_ext < 7'(2 * SCAN_LINES));
    assign row_in_half = row_upper ? row_ext : (row_ext - 7'(SCAN_LINES));
    assign row_line    = row_in_half[LINE_W-1:0];
    assign pcol_ext    = {3'b000, pixel_column};
    assign pcol_ok     = (pcol_ext < 9'(PANEL_COLUMNS));
    assign pcol_idx    = pcol_ext[COL_W-1:0];

    assign we_upper = cmd.clr_step || (cmd.pix_write && row_ok && pcol_ok && row_upper);
    assign we_lower = cmd.clr_step || (cmd.pix_write && row_ok && pcol_ok && !row_upper);
    assign waddr    = cmd.clr_step ? sweep_reg : {row_line, pcol_idx};
    assign wdata    = cmd.clr_step ? '0 : pixel_color;
    assign raddr    = {line_reg, col_reg};

    rlpsd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_upper_ram (
        .clk   (clk),
        .we    (we_upper),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.scan_step),
        .raddr (raddr),
        .rdata (upper_rgb)
    );

    rlpsd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_lower_ram (
        .clk   (clk),
        .we    (we_lower),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.scan_step),
        .raddr (raddr),
        .rdata (lower_rgb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            col_reg       <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.scan_step)
            begin
                out_valid_reg <= 1'b1;
                if (col_last)
                begin
                    col_reg <= '0;
                    if (line_reg == LINE_W'(SCAN_LINES - 1))
                    begin
                        line_reg <= '0;
                    end
                    else
                    begin
                        line_reg <= line_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            else if (rd_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Side fields travel alongside the RAM read data
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            out_col_reg  <= col_ext[COL_OUT_W-1:0];
            out_line_reg <= line_ext[LINE_OUT_W-1:0];
            out_last_reg <= col_last;
        end
    end

    assign status.sweep_last = (sweep_reg == '1);
    assign status.col_last   = col_last;
    assign status.rd_free    = rd_free;

    assign out_valid    = out_valid_reg;
    assign shift_column = out_col_reg;
    assign line_address = out_line_reg;
    assign last_of_line = out_last_reg;

endmodule

`default_nettype wire

/* design/rgb_led_panel_scan_driver.sv */
// Top level of the RGB LED panel frame buffer and scan driver
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  input   | in_valid / in_ready  | operation, pixel_row, pixel_column, pixel_color
//  output  | out_valid / out_ready| upper_rgb, lower_rgb, shift_column, line_address,
//          |                      | last_of_line
//
// A write is stored when it is accepted; an unused operation code is dropped.
// A refresh is accepted from idle, then reads out one column a cycle while the
// sink does not stall, set by the single read port of each frame half.
// A clear, and the clearing pass after reset, sweeps 2**(clog2(PANEL_COLUMNS) +
// clog2(SCAN_LINES)) store addresses (1024 at 64x32) with in_ready low; the
// store is written one address a cycle.
// A stall on out_ready holds the column counter and the read data registers.
`default_nettype none
`include "assert_macros.svh"

module rgb_led_panel_scan_driver
    import rlpsd_pkg::*;
#(
    parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
    parameter int SCAN_LINES    = DEF_SCAN_LINES
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [ROW_IN_W-1:0]   pixel_row,
    input  wire logic [COL_IN_W-1:0]   pixel_column,
    input  wire logic [COLOR_W-1:0]    pixel_color,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COLOR_W-1:0]         upper_rgb,
    output logic [COLOR_W-1:0]         lower_rgb,
    output logic [COL_OUT_W-1:0]       shift_column,
    output logic [LINE_OUT_W-1:0]      line_address,
    output logic                       last_of_line
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Controller: owns the input handshake and sequences each transaction
    rlpsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: frame store split into upper and lower halves, so one read
    // address yields both colours of a column; results leave from the RAM
    // read registers and their side registers
    rlpsd_datapath #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .SCAN_LINES    (SCAN_LINES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .pixel_color  (pixel_color),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .upper_rgb    (upper_rgb),
        .lower_rgb    (lower_rgb),
        .shift_column (shift_column),
        .line_address (line_address),
        .last_of_line (last_of_line)
    );

    // The write port never serves a pixel write or clear while a column is read
    `RLPSD_ASSERT_ALWAYS(a_no_rw_overlap, !(cmd.scan_step && (cmd.pix_write || cmd.clr_step)), "store written during scan read")

    // Issuing the last column must present a result marked last
    `RLPSD_ASSERT_CLK(a_last_marked, (cmd.scan_step && status.col_last) |=> (out_valid && last_of_line), "last column not marked")

    // A taken result that is not last is followed by the next column at once
    `RLPSD_ASSERT_CLK(a_line_continues, (out_valid && out_ready && !last_of_line) |=> out_valid, "gap within a scan line")

endmodule

`default_nettype wire

/* dv/rgb_led_panel_scan_checker.sv */
// Scoreboard for the LED panel scan driver: frame store model, expected column beats, compare
`timescale 1ns / 1ps

module rgb_led_panel_scan_checker
    import rlpsd_pkg::*;
#(
    parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
    parameter int SCAN_LINES    = DEF_SCAN_LINES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [OP_W-1:0]       operation,
    input  logic [ROW_IN_W-1:0]   pixel_row,
    input  logic [COL_IN_W-1:0]   pixel_column,
    input  logic [COLOR_W-1:0]    pixel_color,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [COLOR_W-1:0]    upper_rgb,
    input  logic [COLOR_W-1:0]    lower_rgb,
    input  logic [COL_OUT_W-1:0]  shift_column,
    input  logic [LINE_OUT_W-1:0] line_address,
    input  logic                  last_of_line,
    output int                    mismatch_count,
    output int                    pending_beats
);

    typedef struct packed {
        logic [COLOR_W-1:0]    upper;
        logic [COLOR_W-1:0]    lower;
        logic [COL_OUT_W-1:0]  column;
        logic [LINE_OUT_W-1:0] line;
        logic                  last;
    } column_beat_t;

    logic [COLOR_W-1:0] frame_model [0:2*SCAN_LINES-1][0:PANEL_COLUMNS-1];
    int                 scan_line_idx;
    column_beat_t       beat_queue [$];

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s: got %0h, wanted %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        column_beat_t want;
        column_beat_t beat;
        if (!rst_n)
        begin
            for (int r = 0; r < 2*SCAN_LINES; r++)
                for (int c = 0; c < PANEL_COLUMNS; c++)
                    frame_model[r][c] = '0;
            scan_line_idx  = 0;
            beat_queue.delete();
            mismatch_count = 0;
            pending_beats <= 0;
        end
        else
        begin
            // Check the outgoing column beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (beat_queue.size() == 0)
                    report_mismatch("unexpected beat, column", 16'(shift_column), 16'h0);
                else
                begin
                    want = beat_queue.pop_front();
                    if (upper_rgb !== want.upper)
                        report_mismatch("upper_rgb", 16'(upper_rgb), 16'(want.upper));
                    if (lower_rgb !== want.lower)
                        report_mismatch("lower_rgb", 16'(lower_rgb), 16'(want.lower));
                    if (shift_column !== want.column)
                        report_mismatch("shift_column", 16'(shift_column), 16'(want.column));
                    if (line_address !== want.line)
                        report_mismatch("line_address", 16'(line_address), 16'(want.line));
                    if (last_of_line !== want.last)
                        report_mismatch("last_of_line", 16'(last_of_line), 16'(want.last));
                end
            end

            // Advance the model on an accepted transaction
            if (in_valid && in_ready)
            begin
                case (operation)
                    OP_WRITE:
                    begin
                        if (pixel_row < 2*SCAN_LINES && pixel_column < PANEL_COLUMNS)
                            frame_model[pixel_row][pixel_column] = pixel_color;
                    end
                    OP_CLEAR:
                    begin
                        for (int r = 0; r < 2*SCAN_LINES; r++)
                            for (int c = 0; c < PANEL_COLUMNS; c++)
                                frame_model[r][c] = '0;
                    end
                    OP_REFRESH:
                    begin
                        for (int c = 0; c < PANEL_COLUMNS; c++)
                        begin
                            beat.upper  = frame_model[scan_line_idx][c];
                            beat.lower  = frame_model[scan_line_idx + SCAN_LINES][c];
                            beat.column = c[COL_OUT_W-1:0];
                            beat.line   = scan_line_idx[LINE_OUT_W-1:0];
                            beat.last   = (c == PANEL_COLUMNS - 1);
                            beat_queue.push_back(beat);
                        end
                        scan_line_idx = (scan_line_idx + 1) % SCAN_LINES;
                    end
                    default:
                    begin
                        // unused code: drop
                    end
                endcase
            end
            pending_beats <= beat_queue.size();
        end
    end

endmodule

/* dv/rgb_led_panel_scan_driver_tb.sv */
// Testbench top for the LED panel scan driver: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module rgb_led_panel_scan_driver_tb;
    import rlpsd_pkg::*;

    localparam int PANEL_COLUMNS = DEF_PANEL_COLUMNS;
    localparam int SCAN_LINES    = DEF_SCAN_LINES;

    // The one operation code the package leaves unnamed; the block must drop it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles with no transaction on either channel before the run is abandoned.
    // The longest legitimate quiet spell is a clear sweep followed by a random
    // sender gap, so this leaves ample margin.
    localparam int WATCHDOG_LIMIT = 5000;

    // Random transactions (writes, clears, refreshes) to send in each idling phase
    localparam int ITEMS_PER_PHASE = 24;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       operation = OP_WRITE;
    logic [ROW_IN_W-1:0]   pixel_row = '0;
    logic [COL_IN_W-1:0]   pixel_column = '0;
    logic [COLOR_W-1:0]    pixel_color = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COLOR_W-1:0]    upper_rgb;
    logic [COLOR_W-1:0]    lower_rgb;
    logic [COL_OUT_W-1:0]  shift_column;
    logic [LINE_OUT_W-1:0] line_address;
    logic                  last_of_line;

    int mismatch_count;
    int pending_beats;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;
    int next_line          = 0;

    always #4 clk = ~clk;

    rgb_led_panel_scan_driver #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .SCAN_LINES    (SCAN_LINES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .pixel_color  (pixel_color),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .upper_rgb    (upper_rgb),
        .lower_rgb    (lower_rgb),
        .shift_column (shift_column),
        .line_address (line_address),
        .last_of_line (last_of_line)
    );

    // Scoreboard sits beside the block and only watches the two channels
    rgb_led_panel_scan_checker #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .SCAN_LINES    (SCAN_LINES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .pixel_row      (pixel_row),
        .pixel_column   (pixel_column),
        .pixel_color    (pixel_color),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .upper_rgb      (upper_rgb),
        .lower_rgb      (lower_rgb),
        .shift_column   (shift_column),
        .line_address   (line_address),
        .last_of_line   (last_of_line),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    // Receiver back-pressure: redraw ready every cycle at the current stall rate
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Watchdog: abandon the run if neither channel moves a transaction for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Present one transaction and hold it until accepted. Call this in the time
    // step just after a rising edge; it returns in the step of the accepting edge,
    // so the next call may raise valid again without a second assignment there.
    task automatic send_item(input logic [OP_W-1:0]     op,
                             input logic [ROW_IN_W-1:0] row,
                             input logic [COL_IN_W-1:0] col,
                             input logic [COLOR_W-1:0]  color);
        logic ready_seen;
        // Insert a random gap before the transaction at the sender idle rate
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        pixel_row    <= row;
        pixel_column <= col;
        pixel_color  <= color;
        // Sample ready mid-cycle, where it is settled, then step to the edge
        do
        begin
            @(negedge clk);
            ready_seen = in_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        if (op == OP_REFRESH)
            next_line = (next_line + 1) % SCAN_LINES;
    endtask

    // Drop valid and hold off until every predicted column beat has been checked
    task automatic drain_beats();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_beats != 0);
        @(posedge clk);
    endtask

    // One well-formed burst: a few writes (biased towards the two rows that the
    // next refresh will show), with the odd clear or unused code as noise, then
    // a refresh. Returns the number of transactions that count towards the quota.
    task automatic send_burst(output int counted);
        int n_writes;
        int pick;
        logic [ROW_IN_W-1:0] row;
        counted  = 0;
        n_writes = $urandom_range(0, 5);
        for (int i = 0; i < n_writes; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                send_item(OP_CLEAR, ROW_IN_W'($urandom), COL_IN_W'($urandom),
                          COLOR_W'($urandom));
                counted++;
            end
            else if (pick < 8)
            begin
                // ignored by the block: do not count it
                send_item(OP_UNUSED, ROW_IN_W'($urandom), COL_IN_W'($urandom),
                          COLOR_W'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 1))
                    row = ROW_IN_W'(next_line + SCAN_LINES * $urandom_range(0, 1));
                else
                    row = ROW_IN_W'($urandom_range(0, 2*SCAN_LINES - 1));
                send_item(OP_WRITE, row, COL_IN_W'($urandom_range(0, PANEL_COLUMNS - 1)),
                          COLOR_W'($urandom));
                counted++;
            end
        end
        send_item(OP_REFRESH, ROW_IN_W'($urandom), COL_IN_W'($urandom), COLOR_W'($urandom));
        counted++;
    endtask

    initial
    begin : stimulus
        int sent;
        int burst_count;

        // Hold reset at the start, then release it once for the whole run
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ---------------- directed part ----------------
        // Refresh straight after the clearing pass: line 0 must be all black
        send_item(OP_REFRESH, 5'd31, 6'd63, 3'd7);

        // Corners, some in full-scale colour, for line 1 and its lower-half partner
        send_item(OP_WRITE, 5'd1,  6'd0,  3'd7);
        send_item(OP_WRITE, 5'd17, 6'd63, 3'd7);
        send_item(OP_WRITE, 5'd1,  6'd63, 3'd2);
        send_item(OP_WRITE, 5'd17, 6'd0,  3'd5);
        // The unused code aimed at a pixel of line 1 must leave the store alone
        send_item(OP_UNUSED, 5'd1, 6'd32, 3'd7);
        send_item(OP_REFRESH, 5'd0, 6'd0, 3'd0);

        // Clear wipes pixels written just before it: line 2 must show black
        send_item(OP_WRITE, 5'd2,  6'd10, 3'd6);
        send_item(OP_WRITE, 5'd18, 6'd20, 3'd3);
        send_item(OP_CLEAR, 5'd0,  6'd0,  3'd0);
        send_item(OP_REFRESH, 5'd21, 6'd42, 3'd5);

        // Overwrite of a pixel keeps the last colour
        send_item(OP_WRITE, 5'd3,  6'd42, 3'd1);
        send_item(OP_WRITE, 5'd19, 6'd21, 3'd6);
        send_item(OP_WRITE, 5'd3,  6'd42, 3'd4);
        send_item(OP_WRITE, 5'd31, 6'd63, 3'd7);
        send_item(OP_WRITE, 5'd15, 6'd31, 3'd1);
        send_item(OP_REFRESH, 5'd10, 6'd21, 3'd2);

        // Let the receiver alone drain the directed beats
        drain_beats();

        // ---------------- random part, four idling phases ----------------
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 73;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 73;
                end
                default:
                begin
                    sender_idle_pct    = 27;
                    receiver_stall_pct = 27;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                send_burst(burst_count);
                sent += burst_count;
            end
            // Hold off the sender until the scoreboard is empty between phases
            drain_beats();
        end

        // Wait out the block's own latency after the last beat, then judge
        repeat (PANEL_COLUMNS + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* rgb_led_panel_scan_driver.f */
+incdir+design
design/rlpsd_pkg.sv
design/rlpsd_ram.sv
design/rlpsd_ctrl.sv
design/rlpsd_datapath.sv
design/rgb_led_panel_scan_driver.sv
dv/rgb_led_panel_scan_checker.sv
dv/rgb_led_panel_scan_driver_tb.sv
